// File: src/i2cbm_pkg.sv
// Package with the shared types and constants of the I2C bit-level master.
package i2cbm_pkg;

   // Command codes carried in the operation field
   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_STOP  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_WACK  = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // Configuration register indexes
   localparam logic CSR_DELAY_TICKS = 1'b0;
   localparam logic CSR_ACK_POLL    = 1'b1;

   localparam logic [15:0] DELAY_TICKS_RST = 16'd10;
   localparam logic [7:0]  ACK_POLL_RST    = 8'd100;
   localparam logic [3:0]  BYTE_BITS       = 4'd8;

   typedef enum logic [4:0] {
      PH_IDLE, ST_A, ST_B, ST_C, SP_A, SP_B, SP_C,
      WR_PRE, WR_HI, WR_LO, WR_END,
      WA_A, WA_B, WA_POLL, WA_END,
      RD_LO, RD_HI, AK_A, AK_B, AK_C
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] operation;
      logic [7:0] data_byte;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_timeout;
   } rsp_type;

endpackage

// File: src/i2c_bit_level_master.sv
// I2C bit-level master: pin sequencer advanced one tick per request transaction.
//
// Usage
//   Every request transaction on req_* is one tick of the bus sequencer. Its
//   payload offers a command (start, stop, write byte, wait ack, read byte)
//   together with the sampled SDA level of that tick. Every request produces
//   exactly one response transaction on rsp_* with the pin levels (SCL, SDA,
//   SDA drive enable), busy/done flags, the last read byte and the ack
//   timeout flag as they stand after that tick.
//   Output: the response is registered.
//   Throughput: one request per cycle while req_ready is high; the sequencer state advances in a
//   single pass of combinational logic between the state registers.
//   Stall: an output register plus a one-entry skid stage sit on the response
//   side, so a request is still taken while a response waits; req_ready drops
//   only when both hold a response.
//   Reset (synchronous, active high): sequencer goes idle with SCL high, SDA
//   driven low, counters cleared, delay_ticks 10 and ack_poll_limit 100;
//   both response stages empty.
//   csr_*: write delay_ticks (index 0) or ack_poll_limit (index 1) while idle.
module i2c_bit_level_master (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cbm_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cbm_pkg::rsp_type  rsp_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata
);
   import i2cbm_pkg::*;

   // configuration
   logic [15:0] delay_ticks_ff;
   logic [7:0]  ack_poll_ff;

   // sequencer state
   phase_type   phase_ff,       phase_in;
   logic [15:0] delay_count_ff, delay_count_in;
   logic [2:0]  delays_left_ff, delays_left_in;
   logic [3:0]  bit_count_ff,   bit_count_in;
   logic [7:0]  shift_ff,       shift_in;
   logic [7:0]  poll_count_ff,  poll_count_in;
   logic        scl_ff,         scl_in;
   logic        sda_ff,         sda_in;
   logic        sda_dir_ff,     sda_dir_in;
   logic        timeout_ff,     timeout_in;
   logic        ack_choice_ff,  ack_choice_in;
   logic [7:0]  read_result_ff, read_result_in;
   logic        done_in;

   // response stages
   logic        out_valid_ff,  skid_valid_ff;
   rsp_type     out_data_ff,   skid_data_ff;
   rsp_type     rsp_in;

   logic        accept;

   // Take a request unless the skid stage is occupied.
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff <= DELAY_TICKS_RST;
         ack_poll_ff    <= ACK_POLL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DELAY_TICKS: delay_ticks_ff <= csr_wdata;
            CSR_ACK_POLL:    ack_poll_ff    <= csr_wdata[7:0];
            default:         ack_poll_ff    <= ack_poll_ff;
         endcase
      end
   end

   // Next-state logic: one tick of the sequencer.
   always_comb begin
      logic        enter;
      phase_type   tgt;
      logic [7:0]  shift_base;
      logic [3:0]  bit_base;
      logic [3:0]  bit_inc;
      logic        adv;
      logic [15:0] cnt_m;
      logic [2:0]  left_m;
      logic [2:0]  units;

      phase_in       = phase_ff;
      delay_count_in = delay_count_ff;
      delays_left_in = delays_left_ff;
      poll_count_in  = poll_count_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      sda_dir_in     = sda_dir_ff;
      timeout_in     = timeout_ff;
      ack_choice_in  = ack_choice_ff;
      read_result_in = read_result_ff;
      done_in        = 1'b0;
      enter          = 1'b0;
      tgt            = PH_IDLE;
      shift_base     = shift_ff;
      bit_base       = bit_count_ff;
      bit_inc        = bit_count_ff + 4'd1;
      adv            = 1'b0;
      cnt_m          = delay_count_ff - 16'd1;
      left_m         = delays_left_ff - 3'd1;
      units          = 3'd0;

      if (phase_ff == PH_IDLE) begin
         if (req_data.cmd_valid) begin
            unique case (req_data.operation)
               OP_START: begin
                  enter = 1'b1;
                  tgt   = ST_A;
               end
               OP_STOP: begin
                  enter = 1'b1;
                  tgt   = SP_A;
               end
               OP_WRITE: begin
                  enter      = 1'b1;
                  tgt        = WR_PRE;
                  shift_base = req_data.data_byte;
               end
               OP_WACK: begin
                  enter      = 1'b1;
                  tgt        = WA_A;
                  timeout_in = 1'b0;
               end
               OP_READ: begin
                  enter         = 1'b1;
                  tgt           = RD_LO;
                  ack_choice_in = req_data.send_ack;
                  bit_base      = 4'd0;
                  shift_base    = 8'd0;
               end
               default: enter = 1'b0;   // undefined codes leave the engine idle
            endcase
         end
      end else if (phase_ff == WA_POLL) begin
         if (!req_data.sda_in) begin
            enter = 1'b1;
            tgt   = WA_END;
         end else if (poll_count_ff >= ack_poll_ff) begin
            timeout_in = 1'b1;
            enter      = 1'b1;
            tgt        = SP_A;
         end else begin
            poll_count_in = poll_count_ff + 8'd1;
         end
      end else begin
         // count down the current delay unit
         if (delays_left_ff == 3'd0 || delay_count_ff == 16'd0) begin
            adv = 1'b1;
         end else begin
            delay_count_in = cnt_m;
            if (cnt_m == 16'd0) begin
               delays_left_in = left_m;
               if (left_m == 3'd0) begin
                  adv = 1'b1;
               end else begin
                  delay_count_in = delay_ticks_ff;
               end
            end
         end
         if (adv) begin
            enter = 1'b1;
            unique case (phase_ff)
               ST_A:    tgt = ST_B;
               ST_B:    tgt = ST_C;
               SP_A:    tgt = SP_B;
               SP_B:    tgt = SP_C;
               WR_PRE:  tgt = WR_HI;
               WR_HI:   tgt = WR_LO;
               WR_LO: begin
                  bit_base = bit_inc;
                  tgt      = (bit_inc < BYTE_BITS) ? WR_HI : WR_END;
               end
               WA_A:    tgt = WA_B;
               WA_B:    tgt = WA_POLL;
               RD_LO:   tgt = RD_HI;
               RD_HI: begin
                  bit_base = bit_inc;
                  if (bit_inc < BYTE_BITS) begin
                     tgt = RD_LO;
                  end else begin
                     read_result_in = shift_ff;
                     tgt            = AK_A;
                  end
               end
               AK_A:    tgt = AK_B;
               AK_B:    tgt = AK_C;
               default: begin
                  // last segment of a command: finish
                  enter    = 1'b0;
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
            endcase
         end
      end

      // apply the pin settings of the entered segment
      if (enter) begin
         phase_in = tgt;
         unique case (tgt)
            ST_A: begin
               sda_dir_in = 1'b1;
               sda_in     = 1'b1;
               scl_in     = 1'b1;
               units      = 3'd5;
            end
            ST_B: begin
               sda_in = 1'b0;
               units  = 3'd3;
            end
            ST_C:   scl_in = 1'b0;
            SP_A: begin
               sda_dir_in = 1'b1;
               scl_in     = 1'b0;
               sda_in     = 1'b0;
               units      = 3'd3;
            end
            SP_B: begin
               scl_in = 1'b1;
               units  = 3'd3;
            end
            SP_C: begin
               sda_in = 1'b1;
               units  = 3'd1;
            end
            WR_PRE: begin
               sda_dir_in = 1'b1;
               scl_in     = 1'b0;
               bit_base   = 4'd0;
            end
            WR_HI: begin
               sda_in     = shift_base[7];
               scl_in     = 1'b1;
               shift_base = {shift_base[6:0], 1'b0};
               units      = 3'd3;
            end
            WR_LO: begin
               scl_in = 1'b0;
               units  = 3'd1;
            end
            WR_END: units = 3'd1;
            WA_A: begin
               sda_dir_in = 1'b0;
               sda_in     = 1'b1;
               units      = 3'd1;
            end
            WA_B: begin
               scl_in = 1'b1;
               units  = 3'd1;
            end
            WA_POLL: poll_count_in = 8'd0;
            WA_END:  scl_in = 1'b0;
            RD_LO: begin
               sda_dir_in = 1'b0;
               scl_in     = 1'b0;
               units      = 3'd3;
            end
            RD_HI: begin
               scl_in     = 1'b1;
               shift_base = {shift_base[6:0], req_data.sda_in};
               units      = 3'd1;
            end
            AK_A: begin
               scl_in     = 1'b0;
               sda_dir_in = 1'b1;
               sda_in     = !ack_choice_ff;
               units      = 3'd3;
            end
            AK_B: begin
               scl_in = 1'b1;
               units  = 3'd3;
            end
            AK_C:    scl_in = 1'b0;
            default: units = 3'd0;
         endcase
         delays_left_in = units;
         delay_count_in = delay_ticks_ff;
      end

      shift_in     = shift_base;
      bit_count_in = bit_base;
   end

   // Output logic: response as it stands after this tick.
   always_comb begin
      rsp_in.scl_out     = scl_in;
      rsp_in.sda_out     = sda_in;
      rsp_in.sda_drive   = sda_dir_in;
      rsp_in.busy_res    = (phase_in != PH_IDLE);
      rsp_in.done_res    = done_in;
      rsp_in.read_byte   = read_result_in;
      rsp_in.ack_timeout = timeout_in;
   end

   // Sequencer registers: advance only on an accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         delay_count_ff <= 16'd0;
         delays_left_ff <= 3'd0;
         bit_count_ff   <= 4'd0;
         shift_ff       <= 8'd0;
         poll_count_ff  <= 8'd0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b0;
         sda_dir_ff     <= 1'b1;
         timeout_ff     <= 1'b0;
         ack_choice_ff  <= 1'b0;
         read_result_ff <= 8'd0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         delay_count_ff <= delay_count_in;
         delays_left_ff <= delays_left_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         poll_count_ff  <= poll_count_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         sda_dir_ff     <= sda_dir_in;
         timeout_ff     <= timeout_in;
         ack_choice_ff  <= ack_choice_in;
         read_result_ff <= read_result_in;
      end
   end

   // Response output register and skid stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && rsp_ready) begin
         // drain: skid first, then a fresh response, else go empty
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (!out_valid_ff) begin
         out_valid_ff <= accept;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && rsp_ready) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (accept) begin
            out_data_ff <= rsp_in;
         end
      end else if (!out_valid_ff) begin
         if (accept) begin
            out_data_ff <= rsp_in;
         end
      end else if (accept) begin
         skid_data_ff <= rsp_in;
      end
   end

endmodule

// File: tb/tb_i2c_bit_level_master.sv
// Testbench for the I2C bit-level master: per-tick pin prediction checked against every response.
`timescale 1ns / 100ps

module tb_i2c_bit_level_master;

   import i2cbm_pkg::*;

   // Highest code the operation field can carry; codes above OP_READ are unused
   localparam logic [2:0] OP_LAST_CODE = 3'd7;
   // Cycles without any accepted transaction before the run is declared hung
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned RANDOM_TICKS = 70;

   // How the SDA level offered with each tick is chosen
   typedef enum {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_policy_type;

   // Tracks the expected pin levels of the sequencer, one entry per request tick
   class bus_pin_scoreboard;
      logic [15:0] delay_ticks;
      logic [7:0]  poll_limit;
      phase_type   phase;
      logic [15:0] unit_ticks_left;
      logic [2:0]  units_left;
      logic [3:0]  bit_idx;
      logic [7:0]  shifter;
      logic [7:0]  poll_cnt;
      logic        scl;
      logic        sda;
      logic        sda_oe;
      logic        timed_out;
      logic        ack_sel;
      logic [7:0]  last_read;
      rsp_type     expected_pins[$];
      int unsigned mismatches;

      function new();
         delay_ticks     = DELAY_TICKS_RST;
         poll_limit      = ACK_POLL_RST;
         phase           = PH_IDLE;
         unit_ticks_left = '0;
         units_left      = '0;
         bit_idx         = '0;
         shifter         = '0;
         poll_cnt        = '0;
         scl             = 1'b1;
         sda             = 1'b0;
         sda_oe          = 1'b1;
         timed_out       = 1'b0;
         ack_sel         = 1'b0;
         last_read       = '0;
         mismatches      = 0;
      endfunction

      function void write_reg(logic index, logic [15:0] value);
         if (index == CSR_DELAY_TICKS) begin
            delay_ticks = value;
         end else begin
            poll_limit = value[7:0];
         end
      endfunction

      // Set the pins of a segment and load its delay units
      function void enter_phase(phase_type p, logic sda_bit);
         logic [2:0] units;
         units = 3'd0;
         phase = p;
         case (p)
            ST_A: begin
               sda_oe = 1'b1; sda = 1'b1; scl = 1'b1; units = 3'd5;
            end
            ST_B: begin
               sda = 1'b0; units = 3'd3;
            end
            ST_C: scl = 1'b0;
            SP_A: begin
               sda_oe = 1'b1; scl = 1'b0; sda = 1'b0; units = 3'd3;
            end
            SP_B: begin
               scl = 1'b1; units = 3'd3;
            end
            SP_C: begin
               sda = 1'b1; units = 3'd1;
            end
            WR_PRE: begin
               sda_oe = 1'b1; scl = 1'b0; bit_idx = '0;
            end
            WR_HI: begin
               sda = shifter[7];
               scl = 1'b1;
               shifter = {shifter[6:0], 1'b0};
               units = 3'd3;
            end
            WR_LO: begin
               scl = 1'b0; units = 3'd1;
            end
            WR_END: units = 3'd1;
            WA_A: begin
               sda_oe = 1'b0; sda = 1'b1; units = 3'd1;
            end
            WA_B: begin
               scl = 1'b1; units = 3'd1;
            end
            WA_POLL: poll_cnt = '0;
            WA_END: scl = 1'b0;
            RD_LO: begin
               sda_oe = 1'b0; scl = 1'b0; units = 3'd3;
            end
            RD_HI: begin
               scl = 1'b1;
               shifter = {shifter[6:0], sda_bit};
               units = 3'd1;
            end
            AK_A: begin
               scl = 1'b0; sda_oe = 1'b1; sda = ack_sel ? 1'b0 : 1'b1; units = 3'd3;
            end
            AK_B: begin
               scl = 1'b1; units = 3'd3;
            end
            AK_C: scl = 1'b0;
            default: ;
         endcase
         units_left = units;
         unit_ticks_left = delay_ticks;
      endfunction

      function phase_type next_phase(phase_type p);
         case (p)
            ST_A: return ST_B;
            ST_B: return ST_C;
            SP_A: return SP_B;
            SP_B: return SP_C;
            WR_PRE: return WR_HI;
            WR_HI: return WR_LO;
            WR_LO: begin
               bit_idx = bit_idx + 4'd1;
               if (bit_idx < BYTE_BITS) return WR_HI;
               return WR_END;
            end
            WA_A: return WA_B;
            WA_B: return WA_POLL;
            RD_LO: return RD_HI;
            RD_HI: begin
               bit_idx = bit_idx + 4'd1;
               if (bit_idx < BYTE_BITS) return RD_LO;
               last_read = shifter;
               return AK_A;
            end
            AK_A: return AK_B;
            AK_B: return AK_C;
            default: return PH_IDLE;
         endcase
      endfunction

      // Advance the sequencer by one accepted tick and queue the pins it leaves behind
      function void note_tick(req_type t);
         logic      advance;
         logic      finished;
         phase_type nxt;
         rsp_type   pins;
         advance  = 1'b0;
         finished = 1'b0;
         if (phase == PH_IDLE) begin
            if (t.cmd_valid) begin
               case (t.operation)
                  OP_START: enter_phase(ST_A, t.sda_in);
                  OP_STOP:  enter_phase(SP_A, t.sda_in);
                  OP_WRITE: begin
                     shifter = t.data_byte;
                     enter_phase(WR_PRE, t.sda_in);
                  end
                  OP_WACK: begin
                     timed_out = 1'b0;
                     enter_phase(WA_A, t.sda_in);
                  end
                  OP_READ: begin
                     ack_sel = t.send_ack;
                     bit_idx = '0;
                     shifter = '0;
                     enter_phase(RD_LO, t.sda_in);
                  end
                  default: ;
               endcase
            end
         end else if (phase == WA_POLL) begin
            if (!t.sda_in) begin
               enter_phase(WA_END, t.sda_in);
            end else if (poll_cnt >= poll_limit) begin
               timed_out = 1'b1;
               enter_phase(SP_A, t.sda_in);
            end else begin
               poll_cnt = poll_cnt + 8'd1;
            end
         end else begin
            if (units_left == 0 || unit_ticks_left == 0) begin
               advance = 1'b1;
            end else begin
               unit_ticks_left = unit_ticks_left - 16'd1;
               if (unit_ticks_left == 0) begin
                  units_left = units_left - 3'd1;
                  if (units_left == 0) begin
                     advance = 1'b1;
                  end else begin
                     unit_ticks_left = delay_ticks;
                  end
               end
            end
            if (advance) begin
               nxt = next_phase(phase);
               if (nxt == PH_IDLE) begin
                  phase = PH_IDLE;
                  finished = 1'b1;
               end else begin
                  enter_phase(nxt, t.sda_in);
               end
            end
         end
         pins.scl_out     = scl;
         pins.sda_out     = sda;
         pins.sda_drive   = sda_oe;
         pins.busy_res    = (phase != PH_IDLE);
         pins.done_res    = finished;
         pins.read_byte   = last_read;
         pins.ack_timeout = timed_out;
         expected_pins.push_back(pins);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            if (mismatches < 10)
               $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_pins(rsp_type got);
         rsp_type want;
         if (expected_pins.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: response %0h arrived with nothing expected", $time, got);
            mismatches++;
            return;
         end
         want = expected_pins.pop_front();
         compare_field("scl_out", want.scl_out, got.scl_out);
         compare_field("sda_out", want.sda_out, got.sda_out);
         compare_field("sda_drive", want.sda_drive, got.sda_drive);
         compare_field("busy_res", want.busy_res, got.busy_res);
         compare_field("done_res", want.done_res, got.done_res);
         compare_field("read_byte", want.read_byte, got.read_byte);
         compare_field("ack_timeout", want.ack_timeout, got.ack_timeout);
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   bus_pin_scoreboard pin_board;
   sda_policy_type    sda_policy = SDA_RANDOM;
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_idle_pct = 0;
   int unsigned       ticks_sent = 0;
   int unsigned       stall_cycles = 0;

   i2c_bit_level_master i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .csr_we,
      .csr_index,
      .csr_wdata
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Response side: check what is accepted at this edge, then pick the next ready level.
   // Values read right after the edge are the ones the edge sampled.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         pin_board.check_pins(rsp_data);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Count cycles in which neither channel moves a transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      @(posedge clock);
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   // Fully random tick: every field and every operation code, unused ones included
   function automatic req_type random_req();
      req_type t;
      t.cmd_valid = 1'($urandom_range(1));
      t.operation = 3'($urandom_range(OP_LAST_CODE));
      t.data_byte = 8'($urandom_range(255));
      t.send_ack  = 1'($urandom_range(1));
      t.sda_in    = 1'($urandom_range(1));
      return t;
   endfunction

   // Tick offered while a command runs or as idle noise: random command noise (ignored by a busy
   // engine), SDA level following the current policy
   function automatic req_type filler_tick();
      req_type t;
      t = random_req();
      case (sda_policy)
         SDA_HIGH: t.sda_in = 1'b1;
         SDA_LOW:  t.sda_in = 1'b0;
         default: begin
            // bias toward a late acknowledge so polling runs a few samples
            if (pin_board.phase == WA_POLL)
               t.sda_in = ($urandom_range(3) != 0);
         end
      endcase
      return t;
   endfunction

   // Offer one tick, with an optional random gap first; hold valid and payload until
   // accepted. Valid stays high on return so back-to-back transactions need no re-raise.
   task automatic send_tick(input req_type t);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pin_board.note_tick(t);
      ticks_sent++;
   endtask

   // Issue one command from idle and keep ticking until the engine is idle again
   task automatic run_command(input logic [2:0] op, input logic [7:0] data,
                              input logic ack, input sda_policy_type policy);
      req_type t;
      sda_policy  = policy;
      t           = filler_tick();
      t.cmd_valid = 1'b1;
      t.operation = op;
      t.data_byte = data;
      t.send_ack  = ack;
      send_tick(t);
      while (pin_board.phase != PH_IDLE) send_tick(filler_tick());
   endtask

   // Finish the running command, drop valid and wait for every response to come back
   task automatic drain_engine();
      while (pin_board.phase != PH_IDLE) send_tick(filler_tick());
      req_valid <= 1'b0;
      while (pin_board.expected_pins.size() != 0) @(posedge clock);
   endtask

   // Write both timing registers while the engine is idle; hold the write enable
   // across the two writes
   task automatic set_bus_timing(input logic [15:0] delay, input logic [7:0] poll);
      drain_engine();
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_DELAY_TICKS;
      csr_wdata <= delay;
      @(posedge clock);
      pin_board.write_reg(CSR_DELAY_TICKS, delay);
      csr_index <= CSR_ACK_POLL;
      csr_wdata <= {8'd0, poll};
      @(posedge clock);
      pin_board.write_reg(CSR_ACK_POLL, {8'd0, poll});
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed bus frames (start, bytes and acks, stop) with random content,
   // mixed with stray ticks and broken frames
   task automatic run_random_traffic(input int unsigned n_ticks);
      int unsigned goal;
      logic        in_frame;
      req_type     t;
      goal     = ticks_sent + n_ticks;
      in_frame = 1'b0;
      while (ticks_sent < goal) begin
         if (pin_board.phase != PH_IDLE) begin
            send_tick(filler_tick());
         end else if ($urandom_range(99) < 15) begin
            // noise: idle tick, unused code or a command out of frame order
            send_tick(filler_tick());
         end else begin
            t = random_req();
            t.cmd_valid = 1'b1;
            if (!in_frame) begin
               t.operation = OP_START;
               in_frame = 1'b1;
            end else begin
               case ($urandom_range(9))
                  0, 1, 2, 8: t.operation = OP_WRITE;
                  3, 4:       t.operation = OP_WACK;
                  5, 6:       t.operation = OP_READ;
                  default: begin
                     t.operation = OP_STOP;
                     in_frame = 1'b0;
                  end
               endcase
            end
            case ($urandom_range(7))
               6:       sda_policy = SDA_HIGH;
               7:       sda_policy = SDA_LOW;
               default: sda_policy = SDA_RANDOM;
            endcase
            send_tick(t);
         end
      end
   endtask

   initial begin
      req_type t;
      pin_board = new();

      // Sender idles rarely, receiver often
      send_idle_pct = 11;
      recv_idle_pct = 76;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed frame at reset timing: ack, read with ACK, timeout with its stop
      run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
      run_command(OP_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
      run_command(OP_WACK, 8'h00, 1'b0, SDA_RANDOM);
      run_command(OP_READ, 8'h00, 1'b1, SDA_HIGH);
      run_command(OP_WACK, 8'h00, 1'b0, SDA_HIGH);
      // Unused codes leave the engine idle
      for (int code = OP_READ + 1; code <= OP_LAST_CODE; code++)
         run_command(3'(code), 8'h5A, 1'b1, SDA_RANDOM);
      // A command without its valid flag is ignored
      t = random_req();
      t.cmd_valid = 1'b0;
      t.operation = OP_START;
      send_tick(t);

      // Zero delay: every segment lasts one tick; zero poll limit times out on one sample
      set_bus_timing(16'd0, 8'd0);
      run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM);
      run_command(OP_WRITE, 8'hFF, 1'b0, SDA_RANDOM);
      run_command(OP_WRITE, 8'h00, 1'b1, SDA_RANDOM);
      run_command(OP_WRITE, 8'h5A, 1'b0, SDA_RANDOM);
      run_command(OP_WACK, 8'h00, 1'b0, SDA_LOW);
      run_command(OP_WACK, 8'h00, 1'b0, SDA_HIGH);
      run_command(OP_READ, 8'h00, 1'b1, SDA_RANDOM);
      run_command(OP_READ, 8'h00, 1'b0, SDA_LOW);
      run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);

      set_bus_timing(16'd1, 8'd255);
      run_random_traffic(RANDOM_TICKS);
      set_bus_timing(16'd2, 8'd3);
      run_random_traffic(RANDOM_TICKS);

      // Swap: sender idles often, receiver rarely
      send_idle_pct = 76;
      recv_idle_pct = 11;
      set_bus_timing(16'd0, 8'd1);
      run_random_traffic(RANDOM_TICKS);
      set_bus_timing(16'd3, ACK_POLL_RST);
      run_random_traffic(RANDOM_TICKS);

      // Full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_bus_timing(16'd1, 8'd0);
      run_random_traffic(RANDOM_TICKS);
      set_bus_timing(16'd0, 8'd255);
      run_random_traffic(RANDOM_TICKS);

      drain_engine();
      repeat (3) @(posedge clock);
      if (pin_board.mismatches == 0 && pin_board.expected_pins.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
